@@ rtl/pphp_pkg.sv @@
`timescale 1ns / 1ps
package pphp_pkg;

  localparam int COUNTER_BITS_DEF = 32;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STATS  = 1'b1;

  localparam logic [4:0]  FILE_HDR_LAST = 5'd23;
  localparam logic [4:0]  REC_HDR_LAST  = 5'd15;
  localparam logic [15:0] ETH_IPV4      = 16'h0800;
  localparam logic [6:0]  IP_OFFSET     = 7'd14;
  localparam logic [31:0] TYPE_HI_POS   = 32'd12;
  localparam logic [31:0] TYPE_LO_POS   = 32'd13;
  localparam logic [31:0] IHL_POS       = 32'd14;
  localparam logic [31:0] PROTO_POS     = 32'd23;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;
  localparam logic [1:0] CLS_ICMP  = 2'd3;

  localparam int OUT_DATA_W = 216;

endpackage

@@ rtl/pphp_sat_cnt.sv @@
`timescale 1ns / 1ps
module pphp_sat_cnt #(
  parameter int W = pphp_pkg::COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clr,
  input  logic         inc,
  output logic [W-1:0] cnt_o
);

  logic [W-1:0] cnt_r;

  // value with this cycle's increment applied, before any clear
  always_comb begin
    cnt_o = cnt_r;
    if (inc && (cnt_r != {W{1'b1}})) begin
      cnt_o = cnt_r + W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_o;
    end
  end

endmodule

@@ rtl/pcap_packet_header_parser.sv @@
`timescale 1ns / 1ps
// Capture file header parser. Takes one file byte per word on in_* (tuser
// high = end of file) and skips the 24-byte file header, then walks 16-byte
// record headers and the packets they describe. A report word leaves on
// out_* when a packet completes (zero-length packets at the last record
// header byte), and a statistics word (tuser = 1) answers an end-of-file
// word, after which the parser is back in its reset state. One word is
// accepted every cycle; a word passes an input register and then the report
// register before its report is valid. The rate is set only by out_tready:
// a report waiting in the output register holds back the next word that
// would produce one. Counters are COUNTER_BITS wide and saturate; their
// low 32 bits are reported.
module pcap_packet_header_parser #(
  parameter int COUNTER_BITS = pphp_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // data_byte
  input  logic                            in_tuser,  // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // packet_number[31:0], captured_length[63:32], ether_type[79:64],
  // protocol_class[81:80], source_port[97:82], destination_port[113:98],
  // tcp_total[145:114], udp_total[177:146], icmp_total[209:178],
  // cut_off[210], zero fill
  output logic [pphp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser  // report_kind
);

  localparam logic [1:0] PH_FILE   = 2'd0;
  localparam logic [1:0] PH_RECORD = 2'd1;
  localparam logic [1:0] PH_PACKET = 2'd2;

  logic       v0_r;
  logic       op0_r;
  logic [7:0] b0_r;

  logic [1:0]  phase_r,  phase_nxt;
  logic [4:0]  pos_r,    pos_nxt;
  logic [31:0] len_r,    len_nxt;
  logic [31:0] early_r,  early_nxt;
  logic [15:0] type_r,   type_nxt;
  logic [3:0]  hw_r,     hw_nxt;
  logic [7:0]  proto_r,  proto_nxt;
  logic [31:0] port_r,   port_nxt;

  logic        res;
  logic        consume;
  logic        pkt_inc;
  logic        fin;
  logic        cut;
  logic [1:0]  cls;
  logic [3:0]  hw_eff;
  logic [6:0]  port_at;
  logic [6:0]  port_diff;
  logic        port_hit;
  logic [32:0] early_inc;

  logic [COUNTER_BITS-1:0] pkt_cnt, tcp_cnt, udp_cnt, icmp_cnt;

  logic                            out_tvalid_r;
  logic                            out_tuser_r, out_tuser_nxt;
  logic [pphp_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign consume   = v0_r && (!res || !out_tvalid_r || out_tready);
  assign in_tready = !v0_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v0_r <= 1'b1;
    end else if (consume) begin
      v0_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op0_r <= in_tuser;
      b0_r  <= in_tdata;
    end
  end

  assign hw_eff    = (early_r == pphp_pkg::IHL_POS) ? b0_r[3:0] : hw_r;
  assign port_at   = pphp_pkg::IP_OFFSET + 7'({hw_eff, 2'b00});
  assign port_diff = early_r[6:0] - port_at;
  assign port_hit  = (early_r[31:7] == '0) && (early_r[6:0] >= port_at) &&
                     (port_diff <= 7'd3);
  assign early_inc = {1'b0, early_r} + 33'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    early_nxt = early_r;
    type_nxt  = type_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    port_nxt  = port_r;
    res       = 1'b0;
    pkt_inc   = 1'b0;
    fin       = 1'b0;
    cut       = 1'b0;
    if (op0_r == pphp_pkg::OP_END) begin
      res       = 1'b1;
      cut       = (phase_r == PH_PACKET) || ((phase_r == PH_RECORD) && (pos_r != '0));
      phase_nxt = PH_FILE;
      pos_nxt   = '0;
      len_nxt   = '0;
      early_nxt = '0;
      type_nxt  = '0;
      hw_nxt    = '0;
      proto_nxt = '0;
      port_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_FILE: begin
          pos_nxt = pos_r + 5'd1;
          if (pos_r == pphp_pkg::FILE_HDR_LAST) begin
            phase_nxt = PH_RECORD;
            pos_nxt   = '0;
          end
        end
        PH_RECORD: begin
          if (pos_r[4:2] == 3'b010) begin
            case (pos_r[1:0])
              2'd0:    len_nxt[7:0]   = b0_r;
              2'd1:    len_nxt[15:8]  = b0_r;
              2'd2:    len_nxt[23:16] = b0_r;
              default: len_nxt[31:24] = b0_r;
            endcase
          end
          pos_nxt = pos_r + 5'd1;
          if (pos_r == pphp_pkg::REC_HDR_LAST) begin
            pkt_inc   = 1'b1;
            early_nxt = '0;
            type_nxt  = '0;
            hw_nxt    = '0;
            proto_nxt = '0;
            port_nxt  = '0;
            pos_nxt   = '0;
            if (len_r == '0) begin
              res = 1'b1;
              fin = 1'b1;
            end else begin
              phase_nxt = PH_PACKET;
            end
          end
        end
        PH_PACKET: begin
          if (early_r == pphp_pkg::TYPE_HI_POS) type_nxt[15:8] = b0_r;
          if (early_r == pphp_pkg::TYPE_LO_POS) type_nxt[7:0]  = b0_r;
          hw_nxt = hw_eff;
          if (early_r == pphp_pkg::PROTO_POS) proto_nxt = b0_r;
          if (port_hit) begin
            case (port_diff[1:0])
              2'd0:    port_nxt[31:24] = b0_r;
              2'd1:    port_nxt[23:16] = b0_r;
              2'd2:    port_nxt[15:8]  = b0_r;
              default: port_nxt[7:0]   = b0_r;
            endcase
          end
          early_nxt = early_inc[31:0];
          if (early_inc >= {1'b0, len_r}) begin
            res = 1'b1;
            fin = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_FILE;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  always_comb begin
    cls = pphp_pkg::CLS_OTHER;
    if (type_nxt == pphp_pkg::ETH_IPV4) begin
      if (proto_nxt == pphp_pkg::PROTO_TCP) begin
        cls = pphp_pkg::CLS_TCP;
      end else if (proto_nxt == pphp_pkg::PROTO_UDP) begin
        cls = pphp_pkg::CLS_UDP;
      end else if (proto_nxt == pphp_pkg::PROTO_ICMP) begin
        cls = pphp_pkg::CLS_ICMP;
      end
    end
  end

  pphp_sat_cnt #(.W(COUNTER_BITS)) u_pkt_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (consume && (op0_r == pphp_pkg::OP_END)),
    .inc   (consume && pkt_inc),
    .cnt_o (pkt_cnt)
  );

  pphp_sat_cnt #(.W(COUNTER_BITS)) u_tcp_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (consume && (op0_r == pphp_pkg::OP_END)),
    .inc   (consume && fin && (cls == pphp_pkg::CLS_TCP)),
    .cnt_o (tcp_cnt)
  );

  pphp_sat_cnt #(.W(COUNTER_BITS)) u_udp_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (consume && (op0_r == pphp_pkg::OP_END)),
    .inc   (consume && fin && (cls == pphp_pkg::CLS_UDP)),
    .cnt_o (udp_cnt)
  );

  pphp_sat_cnt #(.W(COUNTER_BITS)) u_icmp_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (consume && (op0_r == pphp_pkg::OP_END)),
    .inc   (consume && fin && (cls == pphp_pkg::CLS_ICMP)),
    .cnt_o (icmp_cnt)
  );

  always_comb begin
    out_tdata_nxt          = '0;
    out_tuser_nxt          = pphp_pkg::KIND_STATS;
    out_tdata_nxt[31:0]    = 32'(pkt_cnt);
    out_tdata_nxt[145:114] = 32'(tcp_cnt);
    out_tdata_nxt[177:146] = 32'(udp_cnt);
    out_tdata_nxt[209:178] = 32'(icmp_cnt);
    out_tdata_nxt[210]     = cut;
    if (fin) begin
      out_tuser_nxt         = pphp_pkg::KIND_PACKET;
      out_tdata_nxt[63:32]  = len_r;
      out_tdata_nxt[79:64]  = type_nxt;
      out_tdata_nxt[81:80]  = cls;
      if (cls == pphp_pkg::CLS_TCP) begin
        out_tdata_nxt[97:82]  = port_nxt[31:16];
        out_tdata_nxt[113:98] = port_nxt[15:0];
      end
    end
  end

  // finished packet resets the walker to the next record header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      pos_r   <= '0;
      len_r   <= '0;
      early_r <= '0;
      type_r  <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      port_r  <= '0;
    end else if (consume) begin
      if (fin) begin
        phase_r <= PH_RECORD;
        pos_r   <= '0;
        len_r   <= '0;
        early_r <= '0;
        type_r  <= '0;
        hw_r    <= '0;
        proto_r <= '0;
        port_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
        early_r <= early_nxt;
        type_r  <= type_nxt;
        hw_r    <= hw_nxt;
        proto_r <= proto_nxt;
        port_r  <= port_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (consume && res) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && (op0_r == pphp_pkg::OP_END)) |=> (phase_r == PH_FILE) && (pos_r == '0))
    else $error("end of file did not return parser to file header");

  a_file_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FILE) |-> (pos_r <= pphp_pkg::FILE_HDR_LAST))
    else $error("file header position out of range");

  a_packet_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PACKET) |-> ((len_r != '0) && ({1'b0, early_r} < {1'b0, len_r})))
    else $error("packet walk past captured length");

  a_stats_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == pphp_pkg::KIND_STATS)) |-> (out_tdata[113:32] == '0))
    else $error("statistics report carries packet fields");
`endif

endmodule
